// File: design/ihd_pkg.sv
// Package for the impact hit detector: payload types, constants and the LED bar table.
`default_nettype none
package ihd_pkg;

	localparam int MAX_POINTS = 5;
	localparam int LED_COUNT  = 8;
	localparam int HP_W       = 3;
	localparam int LED_W      = 4;
	localparam int SAMPLE_W   = 12;
	localparam int TIME_W     = 32;
	localparam int LOCK_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int HP_ENTRIES = 1 << HP_W;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(800);
	localparam logic [LOCK_W-1:0]   LOCKOUT_RESET   = LOCK_W'(300);
	localparam logic [HP_W-1:0]     HP_FULL         = HP_W'(MAX_POINTS);

	typedef enum logic [0:0] {
		CFG_TRIGGER_LEVEL = 1'b0,
		CFG_LOCKOUT_MS    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [TIME_W-1:0]   now_ms;
		logic                reset_pressed;
	} sample_t;

	typedef struct packed {
		logic                hit;
		logic                died;
		logic [HP_W-1:0]     hp_left;
		logic [LED_W-1:0]    leds_lit;
		logic                bar_shown;
		logic                in_lockout;
		logic                peak_valid;
		logic [SAMPLE_W-1:0] peak_value;
	} result_t;

	typedef logic [LED_W-1:0] led_table_t [HP_ENTRIES];

	function automatic led_table_t build_led_table();
		led_table_t t;
		for (int i = 0; i < HP_ENTRIES; i++) begin
			t[i] = LED_W'((i * LED_COUNT) / MAX_POINTS);
		end
		return t;
	endfunction

	localparam led_table_t LED_TABLE = build_led_table();

endpackage
`default_nettype wire

// File: design/ihd_channels.sv
// Interfaces for the sample, result and configuration channels.
`default_nettype none
interface ihd_sample_if import ihd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ihd_result_if import ihd_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ihd_cfg_if import ihd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	cfg_reg_t              index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// File: design/impact_hit_detector.sv
// Impact hit detector top level: hit counting, lockout, peak hold and health bar.
//
// A sample request on smp carries one sensor sample, the millisecond time and
// the reset button; each one yields exactly one result request on rslt.
// Requests are taken when valid and ready are both high.
// An accepted sample is held in the input register; its result is loaded
// into the output register once that register is free, and rslt.valid
// rises with it; the result is then taken when rslt.ready is high.
// Throughput is one sample per cycle while the receiver does not stall: the hit
// state is updated in the same cycle that the result register is loaded, so
// back-to-back samples see the state left by their predecessor.
// When the receiver stalls, the result register holds its request and the
// input register holds one more sample; smp.ready drops only when both are full.
// The cfg channel writes the trigger level (index 0) or lockout_ms (index 1),
// always ready; user must write it only while no sample is in flight (unchecked).
// Reset (arst_n low) empties both registers, restores the register defaults
// (level 800, lockout 300 ms) and sets full hit points, disarmed, no bar,
// no held peak and last hit time zero.
`default_nettype none
module impact_hit_detector import ihd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ihd_sample_if.sink   smp,
	ihd_result_if.source rslt,
	ihd_cfg_if.sink      cfg
);

	logic [SAMPLE_W-1:0] threshold_q;
	logic [LOCK_W-1:0]   lockout_q;

	logic [HP_W-1:0]     hp_q;
	logic [TIME_W-1:0]   last_hit_q;
	logic                armed_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic                bar_q;

	logic    valid_s1;
	sample_t item_s1;
	logic    out_valid_q;
	result_t out_q;

	logic out_free;
	logic advance;

	logic [TIME_W-1:0]   elapsed;
	logic                cooling;
	logic                above;
	logic                hit;
	logic                died;
	logic                report;
	logic [HP_W-1:0]     hp_d;
	logic [TIME_W-1:0]   last_hit_d;
	logic                armed_d;
	logic [SAMPLE_W-1:0] peak_d;
	logic                bar_d;
	logic                stamp;
	result_t             res_d;

	assign out_free  = !out_valid_q || rslt.ready;
	assign advance   = valid_s1 && out_free;
	assign smp.ready = !valid_s1 || out_free;
	assign cfg.ready = 1'b1;

	assign rslt.valid = out_valid_q;
	assign rslt.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			lockout_q   <= LOCKOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TRIGGER_LEVEL: threshold_q <= cfg.wdata[SAMPLE_W-1:0];
				CFG_LOCKOUT_MS:    lockout_q   <= cfg.wdata[LOCK_W-1:0];
				default:           threshold_q <= threshold_q;
			endcase
		end
	end

	always_comb begin
		elapsed = item_s1.now_ms - last_hit_q;
		cooling = (elapsed[TIME_W-1:LOCK_W] == '0) && (elapsed[LOCK_W-1:0] < lockout_q);
		above   = item_s1.sample > threshold_q;

		hp_d       = hp_q;
		last_hit_d = last_hit_q;
		armed_d    = armed_q;
		peak_d     = peak_q;
		bar_d      = bar_q;
		hit        = 1'b0;
		died       = 1'b0;
		report     = 1'b0;
		stamp      = 1'b0;

		if (item_s1.reset_pressed) begin
			hp_d       = HP_FULL;
			last_hit_d = item_s1.now_ms;
			armed_d    = 1'b0;
			bar_d      = 1'b0;
			stamp      = 1'b1;
		end else begin
			if (cooling) begin
				if (item_s1.sample > peak_q) begin
					peak_d = item_s1.sample;
				end
			end else if (peak_q != '0) begin
				report = 1'b1;
				peak_d = '0;
				bar_d  = 1'b0;
			end
			if (!above) begin
				armed_d = 1'b1;
			end
			if (armed_q && above && !cooling) begin
				hit        = 1'b1;
				armed_d    = 1'b0;
				peak_d     = item_s1.sample;
				last_hit_d = item_s1.now_ms;
				stamp      = 1'b1;
				if (hp_q <= HP_W'(1)) begin
					died  = 1'b1;
					hp_d  = HP_FULL;
					bar_d = 1'b0;
				end else begin
					hp_d  = hp_q - HP_W'(1);
					bar_d = 1'b1;
				end
			end
		end

		res_d.hit        = hit;
		res_d.died       = died;
		res_d.hp_left    = hp_d;
		res_d.leds_lit   = LED_TABLE[hp_d];
		res_d.bar_shown  = bar_d;
		res_d.in_lockout = stamp ? (lockout_q != '0) : cooling;
		res_d.peak_valid = report;
		res_d.peak_value = report ? peak_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			hp_q        <= HP_FULL;
			last_hit_q  <= '0;
			armed_q     <= 1'b0;
			peak_q      <= '0;
			bar_q       <= 1'b0;
		end else begin
			if (smp.ready) begin
				valid_s1 <= smp.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				hp_q        <= hp_d;
				last_hit_q  <= last_hit_d;
				armed_q     <= armed_d;
				peak_q      <= peak_d;
				bar_q       <= bar_d;
			end else if (rslt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (smp.valid && smp.ready) begin
			item_s1 <= smp.data;
		end
		if (advance) begin
			out_q <= res_d;
		end
	end

	a_died_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rslt.valid |-> (!rslt.data.died || rslt.data.hit))
		else $error("died reported without a hit");

	a_hp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rslt.valid |-> (rslt.data.hp_left != '0 && rslt.data.hp_left <= HP_FULL))
		else $error("hit points out of range");

	a_reset_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.reset_pressed) |=>
		(!rslt.data.hit && !rslt.data.peak_valid && rslt.data.hp_left == HP_FULL))
		else $error("reset button request produced a hit or peak report");

endmodule
`default_nettype wire

// File: sim/ihd_hit_checker.sv
// Scoreboard for the impact hit detector: predicts each result from the accepted samples and compares.
module ihd_hit_checker import ihd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	ihd_sample_if  smp,
	ihd_result_if  rslt,
	ihd_cfg_if     cfg,
	output int     mismatches,
	output int     awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [SAMPLE_W-1:0] thr;
	logic [LOCK_W-1:0]   lock_len;
	logic [HP_W-1:0]     hp;
	logic [TIME_W-1:0]   last_hit_ms;
	logic                armed;
	logic [SAMPLE_W-1:0] peak_held;
	logic                bar_on;
	result_t             results_due [$];
	result_t             want;

	function automatic logic lockout_active(input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] elapsed;
		elapsed = now - last_hit_ms;
		return elapsed < TIME_W'(lock_len);
	endfunction

	function automatic result_t score_sample(input sample_t s);
		result_t r;
		logic cooling;
		r = '0;
		if (s.reset_pressed) begin
			hp = HP_FULL;
			last_hit_ms = s.now_ms;
			armed = 1'b0;
			bar_on = 1'b0;
		end else begin
			cooling = lockout_active(s.now_ms);
			if (cooling) begin
				if (s.sample > peak_held)
					peak_held = s.sample;
			end else if (peak_held != '0) begin
				r.peak_valid = 1'b1;
				r.peak_value = peak_held;
				peak_held = '0;
				bar_on = 1'b0;
			end
			if (s.sample <= thr)
				armed = 1'b1;
			if (armed && s.sample > thr && !cooling) begin
				armed = 1'b0;
				peak_held = s.sample;
				r.hit = 1'b1;
				last_hit_ms = s.now_ms;
				if (hp <= 1) begin
					r.died = 1'b1;
					hp = HP_FULL;
					bar_on = 1'b0;
				end else begin
					hp = hp - 1'b1;
					bar_on = 1'b1;
				end
			end
		end
		r.hp_left = hp;
		r.leds_lit = LED_W'((int'(hp) * LED_COUNT) / MAX_POINTS);
		r.bar_shown = bar_on;
		r.in_lockout = lockout_active(s.now_ms);
		return r;
	endfunction

	task automatic check_field(input string label, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			mismatches++;
			$display("%0t %s mismatch: expected %0d, got %0d", $time, label, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_due.delete();
			mismatches = 0;
			thr = THRESHOLD_RESET;
			lock_len = LOCKOUT_RESET;
			hp = HP_FULL;
			last_hit_ms = '0;
			armed = 1'b0;
			peak_held = '0;
			bar_on = 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_TRIGGER_LEVEL: thr = cfg.wdata[SAMPLE_W-1:0];
					CFG_LOCKOUT_MS: lock_len = cfg.wdata[LOCK_W-1:0];
					default: ;
				endcase
			end
			if (rslt.valid && rslt.ready) begin
				if (results_due.size() == 0) begin
					mismatches++;
					$display("%0t unexpected result request: expected none, got %p",
						$time, rslt.data);
				end else begin
					want = results_due.pop_front();
					check_field("hit", want.hit, rslt.data.hit);
					check_field("died", want.died, rslt.data.died);
					check_field("hp_left", want.hp_left, rslt.data.hp_left);
					check_field("leds_lit", want.leds_lit, rslt.data.leds_lit);
					check_field("bar_shown", want.bar_shown, rslt.data.bar_shown);
					check_field("in_lockout", want.in_lockout, rslt.data.in_lockout);
					check_field("peak_valid", want.peak_valid, rslt.data.peak_valid);
					check_field("peak_value", want.peak_value, rslt.data.peak_value);
				end
			end
			if (smp.valid && smp.ready)
				results_due.push_back(score_sample(smp.data));
		end
		awaiting = results_due.size();
	end

endmodule

// File: sim/tb.sv
// Testbench top for the impact hit detector: clock, reset, sample and register stimulus, verdict.
module tb;
	import ihd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES = 6;
	localparam int PER_PHASE = 230;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   awaiting;
	int   items_sent;
	int   src_gap_pct;
	int   sink_stall_pct;
	logic [TIME_W-1:0]   t_ms;
	logic [SAMPLE_W-1:0] cur_thr;
	logic [LOCK_W-1:0]   cur_lock;
	logic [SAMPLE_W-1:0] thr_set [PHASES];
	logic [LOCK_W-1:0]   lock_set [PHASES];

	ihd_sample_if smp_ch ();
	ihd_result_if res_ch ();
	ihd_cfg_if    cfg_ch ();

	impact_hit_detector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp_ch),
		.rslt   (res_ch),
		.cfg    (cfg_ch)
	);

	ihd_hit_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (smp_ch),
		.rslt       (res_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] now,
			input logic rst);
		if (items_sent < 467) begin
			src_gap_pct = 16;
			sink_stall_pct = 63;
		end else if (items_sent < 934) begin
			src_gap_pct = 63;
			sink_stall_pct = 16;
		end else begin
			src_gap_pct = 0;
			sink_stall_pct = 0;
		end
		while ($urandom_range(99) < src_gap_pct) begin
			smp_ch.valid <= 1'b0;
			@(negedge clk);
		end
		smp_ch.valid <= 1'b1;
		smp_ch.data <= '{sample: s, now_ms: now, reset_pressed: rst};
		@(posedge clk);
		while (!smp_ch.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic push_random_sample();
		int unsigned k;
		logic [SAMPLE_W-1:0] s;
		k = $urandom_range(99);
		if (k < 5)
			t_ms = $urandom;
		else if (k < 10)
			t_ms = t_ms;
		else if (k < 75)
			t_ms = t_ms + $urandom_range(0, cur_lock / 4 + 3);
		else
			t_ms = t_ms + $urandom_range(cur_lock / 2, cur_lock * 2 + 10);
		k = $urandom_range(99);
		if (k < 40)
			s = SAMPLE_W'($urandom_range(0, cur_thr));
		else if (k < 80 && cur_thr != '1)
			s = SAMPLE_W'($urandom_range(cur_thr + 1, 4095));
		else
			s = SAMPLE_W'($urandom_range(0, 4095));
		push_sample(s, t_ms, $urandom_range(99) < 3);
	endtask

	task automatic drain();
		smp_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (awaiting != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		thr_set = '{THRESHOLD_RESET, 12'd0, 12'd4095, 12'd2048, 12'd100, 12'd3000};
		lock_set = '{LOCKOUT_RESET, 16'd0, 16'd65535, 16'd1000, 16'd20, 16'd5};
		items_sent = 0;
		src_gap_pct = 0;
		sink_stall_pct = 0;
		cur_thr = THRESHOLD_RESET;
		cur_lock = LOCKOUT_RESET;
		arst_n = 1'b0;
		smp_ch.valid = 1'b0;
		smp_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_TRIGGER_LEVEL;
		cfg_ch.wdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_sample(12'd0, 32'd1000, 1'b0);
		push_sample(12'd4095, 32'd1001, 1'b0);
		push_sample(12'd100, 32'd1100, 1'b0);
		push_sample(12'd900, 32'd1200, 1'b0);
		push_sample(12'd800, 32'd1301, 1'b0);
		push_sample(12'd801, 32'd1302, 1'b0);
		push_sample(12'd0, 32'd1700, 1'b0);
		push_sample(12'd801, 32'd2100, 1'b0);
		push_sample(12'd0, 32'd2500, 1'b0);
		push_sample(12'd801, 32'd2900, 1'b0);
		push_sample(12'd0, 32'd3300, 1'b0);
		push_sample(12'd4095, 32'd3700, 1'b0);
		push_sample(12'd4095, 32'd3800, 1'b1);
		push_sample(12'd0, 32'hFFFF_FF00, 1'b0);
		push_sample(12'd4095, 32'hFFFF_FFF0, 1'b0);
		push_sample(12'd4095, 32'h0000_0010, 1'b0);
		push_sample(12'd0, 32'h0000_0200, 1'b0);
		push_sample(12'd4095, 32'hFFFF_FFFF, 1'b1);
		push_sample(12'd2000, 32'h0000_0000, 1'b0);
		push_sample(12'd0, 32'h0000_1000, 1'b0);
		t_ms = 32'h0000_1000;

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				drain();
				cur_thr = thr_set[p];
				cur_lock = lock_set[p];
				write_reg(CFG_TRIGGER_LEVEL, CFG_DATA_W'(cur_thr));
				write_reg(CFG_LOCKOUT_MS, cur_lock);
			end
			for (int i = 0; i < PER_PHASE; i++)
				push_random_sample();
		end

		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
